FILE: src/bfa_pkg.sv
// Shared types and constants of the barcode fragment aggregator.
`timescale 1ns / 1ps
package bfa_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 64;
    localparam int CTR_W       = 32;
    localparam int RDS_W       = 48;
    localparam int SUP_W       = 16;

    localparam logic [31:0] FREE_LIMIT = 32'd147;
    localparam logic [31:0] MONO_LIMIT = 32'd294;

    // input commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_FRAG = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // result status codes
    localparam logic [2:0] ST_COUNTED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_READ_OK  = 3'd4;
    localparam logic [2:0] ST_BAD_IDX  = 3'd5;

    // where the result word is taken from at commit
    localparam logic [2:0] SRC_ENTRY  = 3'd0; // stored entry as read
    localparam logic [2:0] SRC_UPD    = 3'd1; // bumped counters, written back
    localparam logic [2:0] SRC_NEW0   = 3'd2; // new entry with zeroed counters
    localparam logic [2:0] SRC_INKEY  = 3'd3; // input key, zero fields
    localparam logic [2:0] SRC_BADIDX = 3'd4; // requested index, zero fields
    localparam logic [2:0] SRC_NONE   = 3'd5; // all zero

    // config register index
    localparam logic REG_WHITELIST = 1'b0;

    typedef struct packed {
        logic       latch;     // take the input word
        logic       scan_clr;  // restart the key scan
        logic       scan_step; // read next entry of the scan
        logic       rd_issue;  // read the entry at entry_index
        logic       tgt_hit;   // target = matched entry
        logic       tgt_new;   // target = next free entry
        logic       commit;    // write back and load the result word
        logic [2:0] src;
        logic [2:0] status;
    } t_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       hit;       // compared entry matches the key
        logic       issue_ok;  // scan index below entry count
        logic       inflight;  // a scan read awaits compare
        logic       full;
        logic       idx_ok;    // entry_index below entry count
        logic       whitelist;
        logic       out_free;  // result register can take a word
    } t_sts;

endpackage

FILE: src/bfa_ctrl.sv
// Controller state machine of the barcode fragment aggregator.
`timescale 1ns / 1ps
module bfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bfa_pkg::t_sts i_sts,
    output bfa_pkg::t_ctl o_ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DISP   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic [2:0] r_src, n_src;
    logic [2:0] r_status, n_status;

    assign o_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_src    = r_src;
        n_status = r_status;
        o_ctl    = '0;
        o_ctl.src    = r_src;
        o_ctl.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.latch    = 1'b1;
                    o_ctl.scan_clr = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.cmd)
                    bfa_pkg::CMD_LOAD, bfa_pkg::CMD_FRAG: begin
                        n_state = S_SCAN;
                    end
                    bfa_pkg::CMD_READ: begin
                        n_state = S_COMMIT;
                        if (i_sts.idx_ok) begin
                            o_ctl.rd_issue = 1'b1;
                            n_src    = bfa_pkg::SRC_ENTRY;
                            n_status = bfa_pkg::ST_READ_OK;
                        end else begin
                            n_src    = bfa_pkg::SRC_BADIDX;
                            n_status = bfa_pkg::ST_BAD_IDX;
                        end
                    end
                    default: begin
                        n_state  = S_COMMIT;
                        n_src    = bfa_pkg::SRC_NONE;
                        n_status = bfa_pkg::ST_IGNORED;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_ctl.tgt_hit = 1'b1;
                    n_state       = S_COMMIT;
                    if (i_sts.cmd == bfa_pkg::CMD_LOAD) begin
                        n_src    = bfa_pkg::SRC_ENTRY;
                        n_status = bfa_pkg::ST_IGNORED;
                    end else begin
                        n_src    = bfa_pkg::SRC_UPD;
                        n_status = bfa_pkg::ST_COUNTED;
                    end
                end else if (i_sts.issue_ok) begin
                    o_ctl.scan_step = 1'b1;
                end else if (!i_sts.inflight) begin
                    // key not present
                    n_state = S_COMMIT;
                    if (i_sts.cmd == bfa_pkg::CMD_FRAG && i_sts.whitelist) begin
                        n_src    = bfa_pkg::SRC_INKEY;
                        n_status = bfa_pkg::ST_IGNORED;
                    end else if (i_sts.full) begin
                        n_src    = bfa_pkg::SRC_INKEY;
                        n_status = bfa_pkg::ST_FULL;
                    end else begin
                        o_ctl.tgt_new = 1'b1;
                        n_status      = bfa_pkg::ST_INSERTED;
                        n_src = (i_sts.cmd == bfa_pkg::CMD_LOAD) ? bfa_pkg::SRC_NEW0
                                                                 : bfa_pkg::SRC_UPD;
                    end
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_src    <= n_src;
        r_status <= n_status;
    end

endmodule

FILE: src/bfa_dpath.sv
// Datapath of the barcode fragment aggregator: table memories, scan, counters.
`timescale 1ns / 1ps
module bfa_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfa_pkg::t_ctl               i_ctl,
    output bfa_pkg::t_sts               o_sts,
    // input word
    input  logic [1:0]                  i_cmd,
    input  logic [bfa_pkg::KEY_W-1:0]   i_key,
    input  logic [31:0]                 i_frag_start,
    input  logic [31:0]                 i_frag_end,
    input  logic [bfa_pkg::SUP_W-1:0]   i_read_support,
    input  logic [bfa_pkg::IDX_W-1:0]   i_entry_index,
    // result word
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [2:0]                  o_status,
    output logic [bfa_pkg::IDX_W-1:0]   o_result_index,
    output logic [bfa_pkg::KEY_W-1:0]   o_result_key,
    output logic [bfa_pkg::CTR_W-1:0]   o_fragment_total,
    output logic [bfa_pkg::CTR_W-1:0]   o_mono_total,
    output logic [bfa_pkg::CTR_W-1:0]   o_free_total,
    output logic [bfa_pkg::RDS_W-1:0]   o_reads_total,
    // config
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int DEPTH = bfa_pkg::TABLE_DEPTH;
    localparam int IW    = bfa_pkg::IDX_W;
    localparam int CW    = bfa_pkg::CNT_W;
    localparam int KW    = bfa_pkg::KEY_W;
    localparam int TW    = bfa_pkg::CTR_W;
    localparam int RW    = bfa_pkg::RDS_W;
    localparam int SW    = bfa_pkg::SUP_W;

    // table memories
    logic [KW-1:0] key_mem  [DEPTH];
    logic [TW-1:0] frag_mem [DEPTH];
    logic [TW-1:0] mono_mem [DEPTH];
    logic [TW-1:0] free_mem [DEPTH];
    logic [RW-1:0] rds_mem  [DEPTH];

    logic          r_whitelist;
    logic [CW-1:0] r_count;
    logic [1:0]    r_cmd;
    logic [KW-1:0] r_key;
    logic [31:0]   r_start, r_end;
    logic [SW-1:0] r_sup;
    logic [IW-1:0] r_eidx;
    logic          r_is_free, r_is_mono;
    logic [CW-1:0] r_scan;
    logic          r_cmp_vld;
    logic [IW-1:0] r_cmp_idx;
    logic [IW-1:0] r_tgt;
    logic          r_new;
    logic [KW-1:0] r_rd_key;
    logic [TW-1:0] r_rd_frag, r_rd_mono, r_rd_free;
    logic [RW-1:0] r_rd_rds;

    logic          r_out_vld;
    logic [2:0]    r_o_status;
    logic [IW-1:0] r_o_idx;
    logic [KW-1:0] r_o_key;
    logic [TW-1:0] r_o_frag, r_o_mono, r_o_free;
    logic [RW-1:0] r_o_rds;

    logic          cfg_wr;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [31:0]   len;
    logic [TW-1:0] b_frag, b_mono, b_free, u_frag, u_mono, u_free;
    logic [RW-1:0] b_rds, u_rds;
    logic [RW:0]   rds_sum;
    logic          wr_cnt, wr_key, wr_zero;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bfa_pkg::REG_WHITELIST)
                    && (paddr[1:0] == 2'b00);
    assign prdata = (paddr[2] == bfa_pkg::REG_WHITELIST) ? {31'd0, r_whitelist} : 32'd0;

    // fragment length class
    assign len = r_end - r_start;

    // status to controller
    assign o_sts.cmd       = r_cmd;
    assign o_sts.hit       = r_cmp_vld && (r_rd_key == r_key);
    assign o_sts.issue_ok  = (r_scan < r_count);
    assign o_sts.inflight  = r_cmp_vld;
    assign o_sts.full      = (r_count == CW'(DEPTH));
    assign o_sts.idx_ok    = ({1'b0, r_eidx} < r_count);
    assign o_sts.whitelist = r_whitelist;
    assign o_sts.out_free  = !r_out_vld || i_ready;

    // counter update, from zero for a new entry
    assign b_frag  = r_new ? '0 : r_rd_frag;
    assign b_mono  = r_new ? '0 : r_rd_mono;
    assign b_free  = r_new ? '0 : r_rd_free;
    assign b_rds   = r_new ? '0 : r_rd_rds;
    assign u_frag  = (&b_frag) ? b_frag : b_frag + TW'(1);
    assign u_mono  = (r_is_mono && !(&b_mono)) ? b_mono + TW'(1) : b_mono;
    assign u_free  = (r_is_free && !(&b_free)) ? b_free + TW'(1) : b_free;
    assign rds_sum = {1'b0, b_rds} + {{(RW+1-SW){1'b0}}, r_sup};
    assign u_rds   = rds_sum[RW] ? {RW{1'b1}} : rds_sum[RW-1:0];

    assign wr_cnt  = i_ctl.commit && (i_ctl.src == bfa_pkg::SRC_UPD
                                      || i_ctl.src == bfa_pkg::SRC_NEW0);
    assign wr_key  = wr_cnt && (r_new || i_ctl.src == bfa_pkg::SRC_NEW0);
    assign wr_zero = (i_ctl.src == bfa_pkg::SRC_NEW0);

    assign rd_en   = i_ctl.scan_step || i_ctl.rd_issue;
    assign rd_addr = i_ctl.rd_issue ? r_eidx : r_scan[IW-1:0];

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_key) begin
            key_mem[r_tgt] <= r_key;
        end
        if (wr_cnt) begin
            frag_mem[r_tgt] <= wr_zero ? '0 : u_frag;
            mono_mem[r_tgt] <= wr_zero ? '0 : u_mono;
            free_mem[r_tgt] <= wr_zero ? '0 : u_free;
            rds_mem[r_tgt]  <= wr_zero ? '0 : u_rds;
        end
        if (rd_en) begin
            r_rd_key  <= key_mem[rd_addr];
            r_rd_frag <= frag_mem[rd_addr];
            r_rd_mono <= mono_mem[rd_addr];
            r_rd_free <= free_mem[rd_addr];
            r_rd_rds  <= rds_mem[rd_addr];
        end
    end

    // input latch, scan and target
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd   <= i_cmd;
            r_key   <= i_key;
            r_start <= i_frag_start;
            r_end   <= i_frag_end;
            r_sup   <= i_read_support;
            r_eidx  <= i_entry_index;
        end
        r_is_free <= (r_end >= r_start) && (len < bfa_pkg::FREE_LIMIT);
        r_is_mono <= (r_end >= r_start) && (len > bfa_pkg::FREE_LIMIT)
                     && (len < bfa_pkg::MONO_LIMIT);
        if (i_ctl.scan_clr) begin
            r_scan <= '0;
        end else if (i_ctl.scan_step) begin
            r_scan <= r_scan + CW'(1);
        end
        if (i_ctl.scan_step) begin
            r_cmp_idx <= r_scan[IW-1:0];
        end
        if (i_ctl.tgt_hit) begin
            r_tgt <= r_cmp_idx;
            r_new <= 1'b0;
        end else if (i_ctl.tgt_new) begin
            r_tgt <= r_count[IW-1:0];
            r_new <= 1'b1;
        end else if (i_ctl.rd_issue) begin
            r_tgt <= r_eidx;
            r_new <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_o_status <= i_ctl.status;
            r_o_idx    <= '0;
            r_o_key    <= '0;
            r_o_frag   <= '0;
            r_o_mono   <= '0;
            r_o_free   <= '0;
            r_o_rds    <= '0;
            case (i_ctl.src)
                bfa_pkg::SRC_ENTRY: begin
                    r_o_idx  <= r_tgt;
                    r_o_key  <= r_rd_key;
                    r_o_frag <= r_rd_frag;
                    r_o_mono <= r_rd_mono;
                    r_o_free <= r_rd_free;
                    r_o_rds  <= r_rd_rds;
                end
                bfa_pkg::SRC_UPD: begin
                    r_o_idx  <= r_tgt;
                    r_o_key  <= r_key;
                    r_o_frag <= u_frag;
                    r_o_mono <= u_mono;
                    r_o_free <= u_free;
                    r_o_rds  <= u_rds;
                end
                bfa_pkg::SRC_NEW0: begin
                    r_o_idx <= r_tgt;
                    r_o_key <= r_key;
                end
                bfa_pkg::SRC_INKEY: begin
                    r_o_key <= r_key;
                end
                bfa_pkg::SRC_BADIDX: begin
                    r_o_idx <= r_eidx;
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whitelist <= 1'b0;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_whitelist <= pwdata[0];
            end
            if (wr_key) begin
                r_count <= r_count + CW'(1);
            end
            r_cmp_vld <= i_ctl.scan_step;
            if (i_ctl.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_vld;
    assign o_status         = r_o_status;
    assign o_result_index   = r_o_idx;
    assign o_result_key     = r_o_key;
    assign o_fragment_total = r_o_frag;
    assign o_mono_total     = r_o_mono;
    assign o_free_total     = r_o_free;
    assign o_reads_total    = r_o_rds;

endmodule

FILE: src/barcode_fragment_aggregator_core.sv
// Top level of the barcode fragment aggregator.
//
// Keyed aggregation table: one input word (cmd, key, coordinates, read support,
// entry index) gives exactly one result word. Both channels use valid/ready.
// cmd 0 loads a whitelist key, cmd 1 counts a fragment, cmd 2 reads an entry.
// Key lookup is a linear scan of the key memory in insertion order, one entry
// per cycle through a registered read port. A lookup that misses scans every
// stored entry; a hit ends the scan at the matching entry. A read by index
// reads the one entry it names. The counter read-modify-write happens in the
// commit cycle. One word is in flight at a time; o_ready is high only while
// the controller is idle. The result sits in an output register: a stalled
// receiver holds it there, and the next word is still taken once the
// controller is idle, its result waiting at commit until the register frees.
// Reset clears the entry count, whitelist mode and both valid flags; the
// table contents need no clearing since only entries below the count are
// ever read. Config is an APB-style port, register 0 at address 0 holds
// whitelist mode.
`timescale 1ns / 1ps
module barcode_fragment_aggregator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [bfa_pkg::KEY_W-1:0]   i_key,
    input  logic [31:0]                 i_frag_start,
    input  logic [31:0]                 i_frag_end,
    input  logic [bfa_pkg::SUP_W-1:0]   i_read_support,
    input  logic [bfa_pkg::IDX_W-1:0]   i_entry_index,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_status,
    output logic [bfa_pkg::IDX_W-1:0]   o_result_index,
    output logic [bfa_pkg::KEY_W-1:0]   o_result_key,
    output logic [bfa_pkg::CTR_W-1:0]   o_fragment_total,
    output logic [bfa_pkg::CTR_W-1:0]   o_mono_total,
    output logic [bfa_pkg::CTR_W-1:0]   o_free_total,
    output logic [bfa_pkg::RDS_W-1:0]   o_reads_total,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    bfa_pkg::t_ctl ctl;
    bfa_pkg::t_sts sts;

    bfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    bfa_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_cmd            (i_cmd),
        .i_key            (i_key),
        .i_frag_start     (i_frag_start),
        .i_frag_end       (i_frag_end),
        .i_read_support   (i_read_support),
        .i_entry_index    (i_entry_index),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_result_index   (o_result_index),
        .o_result_key     (o_result_key),
        .o_fragment_total (o_fragment_total),
        .o_mono_total     (o_mono_total),
        .o_free_total     (o_free_total),
        .o_reads_total    (o_reads_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

endmodule

FILE: src/bfa_checker.sv
// Port-level checks of the barcode fragment aggregator, bound to the top level.
`timescale 1ns / 1ps
module bfa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [2:0]                  o_status,
    input logic [bfa_pkg::IDX_W-1:0]   o_result_index,
    input logic [bfa_pkg::KEY_W-1:0]   o_result_key,
    input logic [bfa_pkg::CTR_W-1:0]   o_fragment_total,
    input logic [bfa_pkg::RDS_W-1:0]   o_reads_total
);

    // no result word straight after reset
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_key)
                                && $stable(o_status) && $stable(o_result_index))
        else $error("stalled result word changed");

    // only defined status codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= bfa_pkg::ST_BAD_IDX)
        else $error("undefined status");

    // bad index and full table carry zero fragment and read totals
    a_zero_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == bfa_pkg::ST_BAD_IDX || o_status == bfa_pkg::ST_FULL)
        |-> o_fragment_total == '0 && o_reads_total == '0)
        else $error("counters not zero on rejected word");

    // a counted fragment always shows a nonzero fragment total
    a_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == bfa_pkg::ST_COUNTED) |-> o_fragment_total != '0)
        else $error("counted fragment with zero total");

endmodule

bind barcode_fragment_aggregator_core bfa_checker u_bfa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_result_index   (o_result_index),
    .o_result_key     (o_result_key),
    .o_fragment_total (o_fragment_total),
    .o_reads_total    (o_reads_total)
);

FILE: sim/testbench.sv
// Self-checking testbench for barcode_fragment_aggregator_core.
`timescale 1ns / 1ps
module testbench;

    localparam int IDX_W = bfa_pkg::IDX_W;
    localparam int KEY_W = bfa_pkg::KEY_W;
    localparam int CTR_W = bfa_pkg::CTR_W;
    localparam int RDS_W = bfa_pkg::RDS_W;
    localparam int SUP_W = bfa_pkg::SUP_W;
    localparam int TABLE_DEPTH = bfa_pkg::TABLE_DEPTH;

    localparam logic [1:0] CMD_NOP = 2'd3;   // unused command code

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [CTR_W-1:0] frags;
        logic [CTR_W-1:0] monos;
        logic [CTR_W-1:0] frees;
        logic [RDS_W-1:0] reads;
    } t_tally;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_cmd = '0;
    logic [KEY_W-1:0]   i_key = '0;
    logic [31:0]        i_frag_start = '0;
    logic [31:0]        i_frag_end = '0;
    logic [SUP_W-1:0]   i_read_support = '0;
    logic [IDX_W-1:0]   i_entry_index = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [2:0]         o_status;
    logic [IDX_W-1:0]   o_result_index;
    logic [KEY_W-1:0]   o_result_key;
    logic [CTR_W-1:0]   o_fragment_total;
    logic [CTR_W-1:0]   o_mono_total;
    logic [CTR_W-1:0]   o_free_total;
    logic [RDS_W-1:0]   o_reads_total;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    barcode_fragment_aggregator_core i_dut (.*);

    // shadow of the table
    logic [KEY_W-1:0] shadow_keys  [TABLE_DEPTH];
    logic [CTR_W-1:0] shadow_frags [TABLE_DEPTH];
    logic [CTR_W-1:0] shadow_monos [TABLE_DEPTH];
    logic [CTR_W-1:0] shadow_frees [TABLE_DEPTH];
    logic [RDS_W-1:0] shadow_reads [TABLE_DEPTH];
    int               shadow_count = 0;
    logic             shadow_whitelist = 1'b0;

    t_tally           pending_tallies[$];
    int               mismatches = 0;
    bit               quiet = 1'b0;     // no idling in the last stretch
    logic [KEY_W-1:0] barcode_pool[40];
    int               fresh_keys = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("barcode_fragment_aggregator_core test failed");
        $finish;
    end

    function automatic int find_barcode(logic [KEY_W-1:0] k);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_keys[i] == k) return i;
        return -1;
    endfunction

    function automatic int add_barcode(logic [KEY_W-1:0] k);
        if (shadow_count >= TABLE_DEPTH) return -1;
        shadow_keys[shadow_count]  = k;
        shadow_frags[shadow_count] = '0;
        shadow_monos[shadow_count] = '0;
        shadow_frees[shadow_count] = '0;
        shadow_reads[shadow_count] = '0;
        shadow_count++;
        return shadow_count - 1;
    endfunction

    function automatic t_tally entry_view(logic [2:0] st, int e);
        t_tally t;
        t.status = st;
        t.idx    = e[IDX_W-1:0];
        t.key    = shadow_keys[e];
        t.frags  = shadow_frags[e];
        t.monos  = shadow_monos[e];
        t.frees  = shadow_frees[e];
        t.reads  = shadow_reads[e];
        return t;
    endfunction

    // Expected result of one word; updates the shadow table
    function automatic t_tally tally_word(logic [1:0] cmd, logic [KEY_W-1:0] k,
                                          logic [31:0] fs, logic [31:0] fe,
                                          logic [SUP_W-1:0] sup,
                                          logic [IDX_W-1:0] eidx);
        t_tally      t;
        int          e;
        logic [31:0] len;
        logic [48:0] rsum;
        bit          is_free;
        bit          is_mono;
        logic [2:0]  st;
        t = '0;
        case (cmd)
            bfa_pkg::CMD_LOAD: begin
                e = find_barcode(k);
                if (e >= 0) return entry_view(bfa_pkg::ST_IGNORED, e);
                e = add_barcode(k);
                if (e < 0) begin
                    t.status = bfa_pkg::ST_FULL;
                    t.key = k;
                    return t;
                end
                return entry_view(bfa_pkg::ST_INSERTED, e);
            end
            bfa_pkg::CMD_FRAG: begin
                is_free = 1'b0;
                is_mono = 1'b0;
                if (fe >= fs) begin
                    len = fe - fs;
                    is_free = len < bfa_pkg::FREE_LIMIT;
                    is_mono = len > bfa_pkg::FREE_LIMIT && len < bfa_pkg::MONO_LIMIT;
                end
                st = bfa_pkg::ST_COUNTED;
                e = find_barcode(k);
                if (e < 0) begin
                    t.key = k;
                    if (shadow_whitelist) begin
                        t.status = bfa_pkg::ST_IGNORED;
                        return t;
                    end
                    e = add_barcode(k);
                    if (e < 0) begin
                        t.status = bfa_pkg::ST_FULL;
                        return t;
                    end
                    st = bfa_pkg::ST_INSERTED;
                end
                if (shadow_frags[e] != '1) shadow_frags[e]++;
                if (is_mono && shadow_monos[e] != '1) shadow_monos[e]++;
                if (is_free && shadow_frees[e] != '1) shadow_frees[e]++;
                rsum = {1'b0, shadow_reads[e]} + {33'd0, sup};
                shadow_reads[e] = rsum[RDS_W] ? '1 : rsum[RDS_W-1:0];
                return entry_view(st, e);
            end
            bfa_pkg::CMD_READ: begin
                if (int'(eidx) < shadow_count)
                    return entry_view(bfa_pkg::ST_READ_OK, int'(eidx));
                t.status = bfa_pkg::ST_BAD_IDX;
                t.idx = eidx;
                return t;
            end
            default: begin
                t.status = bfa_pkg::ST_IGNORED;
                return t;
            end
        endcase
    endfunction

    // Send one word, with an occasional idle burst first
    task automatic send_word(logic [1:0] cmd, logic [KEY_W-1:0] k,
                             logic [31:0] fs, logic [31:0] fe,
                             logic [SUP_W-1:0] sup, logic [IDX_W-1:0] eidx);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_cmd = cmd;
        i_key = k;
        i_frag_start = fs;
        i_frag_end = fe;
        i_read_support = sup;
        i_entry_index = eidx;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_tallies.push_back(tally_word(cmd, k, fs, fe, sup, eidx));
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_tallies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_whitelist(logic mode);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = 3'(4 * bfa_pkg::REG_WHITELIST);
        pwdata = {31'd0, mode};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        shadow_whitelist = mode;
    endtask

    // Fragment word with a length drawn from every class
    task automatic send_fragment(logic [KEY_W-1:0] k);
        logic [31:0] fs;
        logic [31:0] fe;
        fs = $urandom;
        case ($urandom_range(0, 6))
            0: fe = fs + $urandom_range(0, 146);
            1: fe = fs + bfa_pkg::FREE_LIMIT;
            2: fe = fs + $urandom_range(148, 293);
            3: fe = fs + bfa_pkg::MONO_LIMIT;
            4: fe = fs - $urandom_range(1, 1000);
            default: fe = $urandom;
        endcase
        send_word(bfa_pkg::CMD_FRAG, k, fs, fe,
                  $urandom_range(0, 3) == 0 ? 16'hFFFF : SUP_W'($urandom), '0);
    endtask

    function automatic logic [KEY_W-1:0] pool_key();
        return barcode_pool[$urandom_range(0, 39)];
    endfunction

    function automatic logic [KEY_W-1:0] wild_key();
        return {32'($urandom), 32'($urandom)};
    endfunction

    // Read a stored entry, one just past the end, or a random index
    task automatic send_read();
        logic [IDX_W-1:0] eidx;
        if ($urandom_range(0, 7) == 0) eidx = IDX_W'($urandom);
        else eidx = IDX_W'($urandom_range(0, shadow_count + 2));
        send_word(bfa_pkg::CMD_READ, wild_key(), $urandom, $urandom, SUP_W'($urandom),
                  eidx);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_tally seen;
        t_tally want;
        if (i_rst_n && o_valid && i_ready) begin
            seen = {o_status, o_result_index, o_result_key, o_fragment_total,
                    o_mono_total, o_free_total, o_reads_total};
            if (pending_tallies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", seen);
            end else begin
                want = pending_tallies.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, seen);
                end
            end
        end
    end

    // Receiver stalls
    initial begin
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            i_ready = 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge i_clk);
        end
    end

    // Extremes, each command, dup loads, bad indexes
    task automatic test_directed();
        send_word(bfa_pkg::CMD_LOAD, '0, '0, '0, '0, '0);
        send_word(bfa_pkg::CMD_LOAD, '1, '0, '0, '0, '0);
        send_word(bfa_pkg::CMD_LOAD, '0, '0, '0, '0, '0);
        send_word(bfa_pkg::CMD_FRAG, '0, 32'd0, 32'd146, 16'hFFFF, '0);
        send_word(bfa_pkg::CMD_FRAG, '0, 32'd10, 32'd157, 16'd0, '0);
        send_word(bfa_pkg::CMD_FRAG, '1, 32'd0, 32'd148, 16'd1, '0);
        send_word(bfa_pkg::CMD_FRAG, '1, 32'd0, 32'd293, 16'd2, '0);
        send_word(bfa_pkg::CMD_FRAG, '1, 32'd0, 32'd294, 16'd3, '0);
        send_word(bfa_pkg::CMD_FRAG, '1, '1, '0, 16'hFFFF, '0);
        send_word(bfa_pkg::CMD_FRAG, 64'h5555_AAAA_1234_5678, '0, '1, 16'hFFFF, '0);
        send_word(bfa_pkg::CMD_FRAG, 64'h5555_AAAA_1234_5678, 32'd500, 32'd500, '0, '0);
        send_word(bfa_pkg::CMD_READ, '0, '0, '0, '0, 12'd0);
        send_word(bfa_pkg::CMD_READ, '0, '0, '0, '0, 12'd2);
        send_word(bfa_pkg::CMD_READ, '0, '0, '0, '0, 12'd3);
        send_word(bfa_pkg::CMD_READ, '1, '1, '1, '1, '1);
        send_word(CMD_NOP, '1, '1, '1, '1, '1);
        drain();
        write_whitelist(1'b1);
        send_word(bfa_pkg::CMD_FRAG, 64'h0123_4567_89AB_CDEF, '0, 32'd100, 16'd9, '0);
        send_word(bfa_pkg::CMD_LOAD, 64'h0123_4567_89AB_CDEF, '0, '0, '0, '0);
        send_word(bfa_pkg::CMD_FRAG, 64'h0123_4567_89AB_CDEF, '0, 32'd100, 16'd9, '0);
        send_word(bfa_pkg::CMD_LOAD, '1, '0, '0, '0, '0);
        drain();
        write_whitelist(1'b0);
    endtask

    // Mostly known barcodes, a few new ones
    task automatic test_open_mix(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1: send_read();
                2: send_word(bfa_pkg::CMD_LOAD, pool_key(), $urandom, $urandom,
                             SUP_W'($urandom), IDX_W'($urandom));
                3: if (fresh_keys < 20 && $urandom_range(0, 3) == 0) begin
                    fresh_keys++;
                    send_fragment(wild_key());
                end else send_word(CMD_NOP, wild_key(), $urandom, $urandom,
                                   SUP_W'($urandom), IDX_W'($urandom));
                default: send_fragment(pool_key());
            endcase
            if (i == n / 2) drain();    // let the table settle once mid-phase
        end
    endtask

    // Only listed barcodes count; strangers are dropped
    task automatic test_whitelist_mix(int n);
        write_whitelist(1'b1);
        for (int i = 0; i < 10; i++)
            send_word(bfa_pkg::CMD_LOAD, pool_key(), $urandom, $urandom,
                      SUP_W'($urandom), IDX_W'($urandom));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: send_read();
                1, 2: send_fragment(wild_key());
                default: send_fragment(pool_key());
            endcase
        end
        drain();
        write_whitelist(1'b0);
    endtask

    initial begin
        for (int i = 0; i < 40; i++) barcode_pool[i] = wild_key();
        barcode_pool[0] = '0;
        barcode_pool[1] = '1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_open_mix(350);
        drain();
        test_whitelist_mix(300);
        quiet = 1'b1;
        test_open_mix(300);
        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("barcode_fragment_aggregator_core test passed");
        else
            $display("barcode_fragment_aggregator_core test failed");
        $finish;
    end
endmodule
